// ----- sv/svmk_pkg.sv -----
// svmk_pkg: shared types and constants of the svm kernel classifier
`default_nettype none

package svmk_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ZERO    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RHO          = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PROB_A       = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PROB_B       = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_COUNT = 4'd7;

  // item function codes
  localparam logic [1:0] FUNC_VECTOR  = 2'd0;
  localparam logic [1:0] FUNC_COEF    = 2'd1;
  localparam logic [1:0] FUNC_FEATURE = 2'd2;

  // kernel modes
  localparam logic [1:0] KERN_LINEAR = 2'd0;
  localparam logic [1:0] KERN_POLY   = 2'd1;
  localparam logic [1:0] KERN_RBF    = 2'd2;
  localparam logic [1:0] KERN_NONE   = 2'd3;

  // fixed point constants
  localparam logic [31:0] ONE_Q16    = 32'd65536;
  localparam logic [30:0] ONE_Q30    = 31'd1073741824;
  localparam logic [29:0] LN2_Q30    = 30'd744261118;
  localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
  localparam logic [20:0] EXP_CUTOFF = 21'd1310720;

  // divider widths
  localparam int unsigned DIV_N_W = 33;
  localparam int unsigned DIV_D_W = 18;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } svmk_div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } svmk_div_rsp_t;

  typedef enum logic [5:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_VEC,
    ST_EL_RD,
    ST_EL_MUL,
    ST_EL_ACC,
    ST_KERN,
    ST_POLY_G,
    ST_POLY_BASE,
    ST_POLY_LOOP,
    ST_POLY_RET,
    ST_POLY_SQ,
    ST_POLY_SQW,
    ST_RBF_LO,
    ST_RBF_HI,
    ST_RBF_SUM,
    ST_EXP_CHK,
    ST_EXP_N,
    ST_EXP_R,
    ST_EXP_MUL,
    ST_EXP_DIV,
    ST_EXP_WAIT,
    ST_EXP_FIN,
    ST_TERM_MUL,
    ST_TERM_ACC,
    ST_SCORE,
    ST_SIG_M1,
    ST_SIG_M2,
    ST_SIG_Z,
    ST_SIG_DIV,
    ST_SIG_WAIT,
    ST_OUT
  } svmk_state_e;

endpackage

`default_nettype wire

// ----- sv/svmk_divider.sv -----
// svmk_divider: unsigned restoring divider, one quotient bit per cycle
`default_nettype none

module svmk_divider import svmk_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  svmk_div_req_t req_i,
  output svmk_div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIV_N_W);

  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DIV_D_W-1:0] rem_q;
  logic [DIV_N_W-1:0] quo_q;
  logic [DIV_D_W-1:0] dsor_q;
  logic [DIV_D_W:0]   rem_sh;
  logic               ge;
  logic [DIV_D_W:0]   rem_sub;

  // one shift-subtract step
  assign rem_sh  = {rem_q, quo_q[DIV_N_W-1]};
  assign ge      = rem_sh >= {1'b0, dsor_q};
  assign rem_sub = rem_sh - {1'b0, dsor_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_N_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // remainder and quotient
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quo_q  <= req_i.dividend;
      dsor_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
      quo_q <= {quo_q[DIV_N_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ----- sv/svm_kernel_classifier.sv -----
// svm_kernel_classifier: two-class svm scorer around one shared multiplier
//
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_ready_o   func, vector_index, element_index, value, last
// out      out  out_valid_o / out_ready_i positive, score, probability
// cfg      in   cfg_valid_i / cfg_ready_o index, data
//
// after reset a clearing pass zeroes the vector and coefficient stores with
// in_ready_o low throughout; cfg writes are taken always
// load items and non-last feature items are stored straight from the idle state
// a last feature item starts a scoring pass over the vc vectors, with extra work
// per degree bit for polynomial kernels and, per vector for rbf, seven divides in
// the exp series; the sigmoid adds one more exp series and one more divide
// one item at a time: in_ready_o stays low until the result is taken
`default_nettype none

module svm_kernel_classifier import svmk_pkg::*; #(
  parameter int unsigned MAX_VECTORS = 64,
  parameter int unsigned MAX_DIMS    = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item input
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           in_func_i,
  input  logic [5:0]           in_vector_index_i,
  input  logic [6:0]           in_element_index_i,
  input  logic signed [31:0]   in_value_i,
  input  logic                 in_last_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_positive_o,
  output logic signed [39:0]   out_score_o,
  output logic [16:0]          out_probability_o,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int unsigned VDEPTH = MAX_VECTORS * MAX_DIMS;
  localparam int unsigned VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
  localparam int unsigned CAW    = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
  localparam int unsigned FAW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned VCW    = $clog2(MAX_VECTORS + 1);
  localparam int unsigned LW     = $clog2(MAX_DIMS + 1);

  function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
    logic signed [15:0] r;
    if (x > 32'sd32767) r = 16'sh7fff;
    else if (x < -32'sd32768) r = 16'sh8000;
    else r = x[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7fff_ffff) r = 32'sh7fff_ffff;
    else if (x < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [63:0] x);
    logic signed [39:0] r;
    if (x > 64'sh0000_007f_ffff_ffff) r = 40'sh7f_ffff_ffff;
    else if (x < -64'sh0000_0080_0000_0000) r = 40'sh80_0000_0000;
    else r = x[39:0];
    return r;
  endfunction

  // configuration registers
  logic [1:0]         kmode_q;
  logic [23:0]        gamma_q;
  logic signed [31:0] coef0_q;
  logic [3:0]         degree_q;
  logic signed [31:0] rho_q;
  logic signed [31:0] prob_a_q;
  logic signed [31:0] prob_b_q;
  logic [6:0]         vcount_q;

  // sequencer
  svmk_state_e state_q, state_d;
  logic [VAW-1:0] clr_q;

  // memories
  logic signed [15:0] vec_mem  [VDEPTH];
  logic signed [31:0] coef_mem [MAX_VECTORS];
  logic signed [15:0] feat_mem [MAX_DIMS];
  logic signed [15:0] vec_rd_q, feat_rd_q;
  logic signed [31:0] coef_rd_q;
  logic               vec_we, coef_we, feat_we;
  logic [VAW-1:0]     vec_waddr, vec_raddr;
  logic [CAW-1:0]     coef_waddr;
  logic signed [15:0] vec_wdata;
  logic signed [31:0] coef_wdata;

  // datapath
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;
  logic signed [40:0] acc_q;
  logic signed [31:0] kern_q;
  logic signed [55:0] score_acc_q;
  logic [63:0]        wide_q;
  logic [57:0]        ex_q;
  logic [4:0]         n_q;
  logic [31:0]        r_q;
  logic [30:0]        h_q;
  logic [2:0]         k_q;
  logic [16:0]        q_q;
  logic signed [31:0] ret_q, tmp_q;
  logic [3:0]         t_q;
  logic               z_neg_q, ret_sig_q;
  logic [VCW-1:0]     v_q;
  logic [VAW-1:0]     vbase_q;
  logic [LW-1:0]      i_q, len_q;
  logic               positive_q;
  logic signed [39:0] score_q;
  logic [16:0]        prob_q;

  svmk_div_req_t div_req;
  svmk_div_rsp_t div_rsp;

  // helper values
  logic               in_fire;
  logic               vi_ok, ei_ok;
  logic [31:0]        vw_full;
  logic [VCW-1:0]     vc_eff;
  logic signed [16:0] el_diff;
  logic [31:0]        ma;
  logic [39:0]        ms;
  logic [17:0]        den;
  logic [34:0]        whole;
  logic [42:0]        rnd;
  logic [16:0]        q_fin;
  logic [56:0]        m_sum;
  logic signed [58:0] z_val;
  logic signed [40:0] dsh;

  assign in_fire  = in_valid_i && in_ready_o;
  assign vi_ok    = 32'(in_vector_index_i) < MAX_VECTORS;
  assign ei_ok    = 32'(in_element_index_i) < MAX_DIMS;
  assign vw_full  = 32'(in_vector_index_i) * 32'(MAX_DIMS) + 32'(in_element_index_i);
  assign vc_eff   = (32'(vcount_q) > MAX_VECTORS) ? VCW'(MAX_VECTORS) : VCW'(vcount_q);
  assign el_diff  = 17'(feat_rd_q) - 17'(vec_rd_q);
  assign ma       = prob_a_q[31] ? 32'(~prob_a_q + 32'sd1) : 32'(prob_a_q);
  assign ms       = score_q[39] ? 40'(~score_q + 40'sd1) : 40'(score_q);
  assign den      = 18'(ONE_Q16) + 18'(q_q);
  assign whole    = {ex_q[20:0], 14'd0};
  assign rnd      = 43'(h_q) + (43'd1 << (6'd13 + 6'(n_q)));
  assign q_fin    = 17'(rnd >> (6'd14 + 6'(n_q)));
  assign m_sum    = 57'(wide_q) + 57'(prod_q[63:16]);
  assign z_val    = ((prob_a_q[31] != score_q[39]) ? -$signed({2'b00, m_sum})
                                                    : $signed({2'b00, m_sum}))
                    + 59'(prob_b_q);
  assign dsh      = acc_q >>> 6;
  assign vec_raddr = vbase_q + VAW'(i_q);
  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmode_q  <= KERN_LINEAR;
      gamma_q  <= '0;
      coef0_q  <= '0;
      degree_q <= 4'd3;
      rho_q    <= '0;
      prob_a_q <= '0;
      prob_b_q <= '0;
      vcount_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_KERNEL_MODE:  kmode_q  <= cfg_data_i[1:0];
        REG_GAMMA:        gamma_q  <= cfg_data_i[23:0];
        REG_COEF_ZERO:    coef0_q  <= $signed(cfg_data_i);
        REG_POLY_DEGREE:  degree_q <= cfg_data_i[3:0];
        REG_RHO:          rho_q    <= $signed(cfg_data_i);
        REG_PROB_A:       prob_a_q <= $signed(cfg_data_i);
        REG_PROB_B:       prob_b_q <= $signed(cfg_data_i);
        REG_VECTOR_COUNT: vcount_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:     if (clr_q == VAW'(VDEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:      if (in_fire && in_func_i == FUNC_FEATURE && in_last_i) state_d = ST_START;
      ST_START:     state_d = (vc_eff == '0) ? ST_OUT : ST_VEC;
      ST_VEC:       state_d = (kmode_q == KERN_NONE) ? ST_TERM_MUL : ST_EL_RD;
      ST_EL_RD:     state_d = ST_EL_MUL;
      ST_EL_MUL:    state_d = ST_EL_ACC;
      ST_EL_ACC:    state_d = (i_q + LW'(1) == len_q) ? ST_KERN : ST_EL_RD;
      ST_KERN: begin
        priority case (kmode_q)
          KERN_POLY: state_d = ST_POLY_G;
          KERN_RBF:  state_d = ST_RBF_LO;
          default:   state_d = ST_TERM_MUL;
        endcase
      end
      ST_POLY_G:    state_d = ST_POLY_BASE;
      ST_POLY_BASE: state_d = ST_POLY_LOOP;
      ST_POLY_LOOP: begin
        priority if (t_q == '0) state_d = ST_TERM_MUL;
        else if (t_q[0]) state_d = ST_POLY_RET;
        else state_d = ST_POLY_SQW;
      end
      ST_POLY_RET:  state_d = ST_POLY_SQ;
      ST_POLY_SQ:   state_d = ST_POLY_SQW;
      ST_POLY_SQW:  state_d = ST_POLY_LOOP;
      ST_RBF_LO:    state_d = ST_RBF_HI;
      ST_RBF_HI:    state_d = ST_RBF_SUM;
      ST_RBF_SUM:   state_d = ST_EXP_CHK;
      ST_EXP_CHK: begin
        if (ex_q > 58'(EXP_CUTOFF)) state_d = ret_sig_q ? ST_SIG_DIV : ST_TERM_MUL;
        else state_d = ST_EXP_N;
      end
      ST_EXP_N:     state_d = ST_EXP_R;
      ST_EXP_R:     state_d = ST_EXP_MUL;
      ST_EXP_MUL:   state_d = ST_EXP_DIV;
      ST_EXP_DIV:   state_d = ST_EXP_WAIT;
      ST_EXP_WAIT: begin
        if (div_rsp.done) state_d = (k_q == 3'd1) ? ST_EXP_FIN : ST_EXP_MUL;
      end
      ST_EXP_FIN:   state_d = ret_sig_q ? ST_SIG_DIV : ST_TERM_MUL;
      ST_TERM_MUL:  state_d = ST_TERM_ACC;
      ST_TERM_ACC:  state_d = (v_q + VCW'(1) == vc_eff) ? ST_SCORE : ST_VEC;
      ST_SCORE:     state_d = ST_SIG_M1;
      ST_SIG_M1:    state_d = ST_SIG_M2;
      ST_SIG_M2:    state_d = ST_SIG_Z;
      ST_SIG_Z:     state_d = ST_EXP_CHK;
      ST_SIG_DIV:   state_d = ST_SIG_WAIT;
      ST_SIG_WAIT:  if (div_rsp.done) state_d = ST_OUT;
      ST_OUT:       if (out_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // outputs: handshakes, memory writes, multiplier operands, divider requests
  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    out_valid_o  = (state_q == ST_OUT);
    vec_we       = 1'b0;
    vec_waddr    = VAW'(vw_full);
    vec_wdata    = sat16(in_value_i);
    coef_we      = 1'b0;
    coef_waddr   = CAW'(in_vector_index_i);
    coef_wdata   = in_value_i;
    feat_we      = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_req      = '0;
    unique case (state_q)
      ST_CLEAR: begin
        vec_we     = 1'b1;
        vec_waddr  = clr_q;
        vec_wdata  = '0;
        coef_we    = 32'(clr_q) < MAX_VECTORS;
        coef_waddr = CAW'(clr_q);
        coef_wdata = '0;
      end
      ST_IDLE: begin
        vec_we  = in_fire && in_func_i == FUNC_VECTOR && vi_ok && ei_ok;
        coef_we = in_fire && in_func_i == FUNC_COEF && vi_ok;
        feat_we = in_fire && in_func_i == FUNC_FEATURE && ei_ok;
      end
      ST_EL_MUL: begin
        if (kmode_q == KERN_RBF) begin
          mul_a = 33'(el_diff);
          mul_b = 33'(el_diff);
        end else begin
          mul_a = 33'(feat_rd_q);
          mul_b = 33'(vec_rd_q);
        end
      end
      ST_POLY_G: begin
        mul_a = $signed(33'(gamma_q));
        mul_b = 33'(kern_q);
      end
      ST_POLY_LOOP: begin
        mul_a = t_q[0] ? 33'(ret_q) : 33'(tmp_q);
        mul_b = 33'(tmp_q);
      end
      ST_POLY_SQ: begin
        mul_a = 33'(tmp_q);
        mul_b = 33'(tmp_q);
      end
      ST_RBF_LO: begin
        mul_a = $signed(33'(gamma_q));
        mul_b = $signed(33'(acc_q[37:6]));
      end
      ST_RBF_HI: begin
        mul_a = $signed(33'(gamma_q));
        mul_b = $signed(33'(acc_q[40:38]));
      end
      ST_EXP_CHK: begin
        mul_a = $signed(33'(ex_q[20:0]));
        mul_b = $signed(33'(LOG2E_Q30));
      end
      ST_EXP_N: begin
        mul_a = $signed(33'(prod_q[50:46]));
        mul_b = $signed(33'(LN2_Q30));
      end
      ST_EXP_MUL: begin
        mul_a = $signed(33'(r_q));
        mul_b = $signed(33'(h_q));
      end
      ST_EXP_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q[62:30];
        div_req.divisor  = DIV_D_W'(k_q);
      end
      ST_TERM_MUL: begin
        mul_a = 33'(coef_rd_q);
        mul_b = 33'(kern_q);
      end
      ST_SIG_M1: begin
        mul_a = $signed(33'(ma));
        mul_b = $signed(33'(ms[39:16]));
      end
      ST_SIG_M2: begin
        mul_a = $signed(33'(ma));
        mul_b = $signed(33'(ms[15:0]));
      end
      ST_SIG_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = z_neg_q ? (33'h1_0000_0000 + 33'(den >> 1))
                                   : ({q_q, 16'd0} + 33'(den >> 1));
        div_req.divisor  = den;
      end
      default: ;
    endcase
  end

  // sequencer state and clearing address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + VAW'(1);
    end
  end

  // loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      vbase_q <= '0;
      i_q     <= '0;
      k_q     <= '0;
      t_q     <= '0;
    end else begin
      unique case (state_q)
        ST_START: begin
          v_q     <= '0;
          vbase_q <= '0;
        end
        ST_VEC:       i_q <= '0;
        ST_EL_ACC:    i_q <= i_q + LW'(1);
        ST_POLY_BASE: t_q <= degree_q;
        ST_POLY_SQW:  t_q <= t_q >> 1;
        ST_EXP_R:     k_q <= 3'd7;
        ST_EXP_WAIT:  if (div_rsp.done) k_q <= k_q - 3'd1;
        ST_TERM_ACC: begin
          v_q     <= v_q + VCW'(1);
          vbase_q <= vbase_q + VAW'(MAX_DIMS);
        end
        default: ;
      endcase
    end
  end

  // shared multiplier, registered product
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && in_func_i == FUNC_FEATURE && in_last_i) begin
          len_q <= ei_ok ? LW'(32'(in_element_index_i) + 32'd1) : LW'(MAX_DIMS);
        end
      end
      ST_START: begin
        score_acc_q <= -56'(rho_q);
        positive_q  <= 1'b0;
        score_q     <= '0;
        prob_q      <= '0;
      end
      ST_VEC: begin
        acc_q  <= '0;
        kern_q <= '0;
      end
      ST_EL_ACC:    acc_q <= acc_q + $signed(prod_q[40:0]);
      ST_KERN:      kern_q <= sat32(64'(dsh));
      ST_POLY_BASE: begin
        tmp_q <= sat32(64'(prod_q >>> 16) + 64'(coef0_q));
        ret_q <= $signed(ONE_Q16);
      end
      ST_POLY_LOOP: if (t_q == '0) kern_q <= ret_q;
      ST_POLY_RET:  ret_q <= sat32(64'(prod_q >>> 16));
      ST_POLY_SQW:  tmp_q <= sat32(64'(prod_q >>> 16));
      ST_RBF_HI:    wide_q <= prod_q[63:0];
      ST_RBF_SUM: begin
        ex_q      <= 58'((wide_q + {prod_q[31:0], 32'd0}) >> 16);
        ret_sig_q <= 1'b0;
      end
      ST_EXP_CHK: begin
        if (ex_q > 58'(EXP_CUTOFF)) begin
          q_q <= '0;
          if (!ret_sig_q) kern_q <= '0;
        end
      end
      ST_EXP_N:     n_q <= prod_q[50:46];
      ST_EXP_R: begin
        r_q <= (whole > prod_q[34:0]) ? 32'(whole - prod_q[34:0]) : '0;
        h_q <= ONE_Q30;
      end
      ST_EXP_WAIT:  if (div_rsp.done) h_q <= ONE_Q30 - 31'(div_rsp.quotient);
      ST_EXP_FIN: begin
        q_q <= q_fin;
        if (!ret_sig_q) kern_q <= $signed(32'(q_fin));
      end
      ST_TERM_ACC:  score_acc_q <= score_acc_q + 56'(prod_q >>> 16);
      ST_SCORE: begin
        score_q    <= sat40(64'(score_acc_q));
        positive_q <= sat40(64'(score_acc_q)) > 40'sd0;
      end
      ST_SIG_M2:    wide_q <= prod_q[63:0];
      ST_SIG_Z: begin
        z_neg_q   <= z_val[58];
        ex_q      <= z_val[58] ? 58'(-z_val) : 58'(z_val);
        ret_sig_q <= 1'b1;
      end
      ST_SIG_WAIT:  if (div_rsp.done) prob_q <= div_rsp.quotient[16:0];
      default: ;
    endcase
  end

  // vector store
  always_ff @(posedge clk_i) begin
    if (vec_we) vec_mem[vec_waddr] <= vec_wdata;
    vec_rd_q <= vec_mem[vec_raddr];
  end

  // coefficient store
  always_ff @(posedge clk_i) begin
    if (coef_we) coef_mem[coef_waddr] <= coef_wdata;
    coef_rd_q <= coef_mem[CAW'(v_q)];
  end

  // feature buffer
  always_ff @(posedge clk_i) begin
    if (feat_we) feat_mem[FAW'(in_element_index_i)] <= sat16(in_value_i);
    feat_rd_q <= feat_mem[FAW'(i_q)];
  end

  svmk_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_positive_o    = positive_q;
  assign out_score_o       = score_q;
  assign out_probability_o = prob_q;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// testbench: svm kernel classifier checked against a fixed-point scoring model
`timescale 1ns / 100ps

module testbench;
  import svmk_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd15;
  localparam int unsigned VEC_SLOTS = 64;
  localparam int unsigned FEAT_SLOTS = 128;
  localparam int unsigned PHASE_ITEMS = 150;

  typedef struct packed {
    logic        positive;
    logic [39:0] score;
    logic [16:0] probability;
  } verdict_t;

  // scoring model plus queue of pending verdicts
  class svm_score_board;
    shortint     sv_mem[VEC_SLOTS*FEAT_SLOTS];
    int          coef_mem[VEC_SLOTS];
    shortint     feat_mem[FEAT_SLOTS];
    int unsigned feat_len;
    logic [1:0]  k_mode;
    logic [23:0] gam;
    int          c_zero;
    logic [3:0]  degree;
    int          rho_r, pa, pb;
    logic [6:0]  vcount;
    verdict_t    pending[$];
    int          errors;

    function new();
      foreach (sv_mem[i]) sv_mem[i] = 0;
      foreach (coef_mem[i]) coef_mem[i] = 0;
      foreach (feat_mem[i]) feat_mem[i] = 0;
      feat_len = 0;
      k_mode = KERN_LINEAR; gam = 0; c_zero = 0; degree = 4'd3;
      rho_r = 0; pa = 0; pb = 0; vcount = 0; errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        REG_KERNEL_MODE:  k_mode = d[1:0];
        REG_GAMMA:        gam = d[23:0];
        REG_COEF_ZERO:    c_zero = d;
        REG_POLY_DEGREE:  degree = d[3:0];
        REG_RHO:          rho_r = d;
        REG_PROB_A:       pa = d;
        REG_PROB_B:       pb = d;
        REG_VECTOR_COUNT: vcount = d[6:0];
        default: ;
      endcase
    endfunction

    function shortint sat16(int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return shortint'(v);
    endfunction

    function longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint mul_q16(longint a, longint b);
      return sat32((a * b) >>> 16);
    endfunction

    // exp(-e) in Q.16 by 2^n range reduction and a Horner series
    function logic [63:0] exp_neg(logic [63:0] e);
      logic [63:0] t, whole, sub, r, h;
      int unsigned n;
      if (e > 64'(EXP_CUTOFF)) return 64'd0;
      t = e * 64'(LOG2E_Q30);
      n = int'(t >> 46);
      whole = e << 14;
      sub = 64'(n) * 64'(LN2_Q30);
      r = (whole > sub) ? whole - sub : 64'd0;
      h = 64'(ONE_Q30);
      for (int k = 7; k >= 1; k--)
        h = 64'(ONE_Q30) - ((r * h) >> 30) / 64'(k);
      return (h + (64'd1 << (13 + n))) >> (14 + n);
    endfunction

    function longint kernel(int v);
      longint acc, d, base, ret, tmp, df;
      logic [63:0] sq;
      acc = 0; sq = 0;
      case (k_mode)
        KERN_LINEAR, KERN_POLY: begin
          for (int i = 0; i < feat_len; i++)
            acc += longint'(feat_mem[i]) * longint'(sv_mem[v*FEAT_SLOTS+i]);
          d = sat32(acc >>> 6);
          if (k_mode == KERN_LINEAR) return d;
          base = ((longint'(gam) * d) >>> 16) + longint'(c_zero);
          tmp = sat32(base);
          ret = 65536;
          for (int unsigned t = degree; t > 0; t = t >> 1) begin
            if (t[0]) ret = mul_q16(ret, tmp);
            tmp = mul_q16(tmp, tmp);
          end
          return ret;
        end
        KERN_RBF: begin
          for (int i = 0; i < feat_len; i++) begin
            df = longint'(feat_mem[i]) - longint'(sv_mem[v*FEAT_SLOTS+i]);
            sq += 64'(df * df);
          end
          return longint'(exp_neg((64'(gam) * (sq >> 6)) >> 16));
        end
        default: return 0;
      endcase
    endfunction

    function verdict_t classify();
      verdict_t    res;
      int unsigned vc;
      longint      acc, score, z;
      logic [63:0] ma, ms, m, ez, q, den, p;
      logic        neg;
      res = '0;
      vc = vcount;
      if (vc == 0) return res;
      if (vc > VEC_SLOTS) vc = VEC_SLOTS;
      acc = -longint'(rho_r);
      for (int v = 0; v < vc; v++)
        acc += (longint'(coef_mem[v]) * kernel(v)) >>> 16;
      score = acc;
      if (score > 64'sd549755813887) score = 64'sd549755813887;
      if (score < -64'sd549755813888) score = -64'sd549755813888;
      // sigmoid argument and probability
      ma = 64'(pa < 0 ? -longint'(pa) : longint'(pa));
      ms = 64'(score < 0 ? -score : score);
      m = ma * (ms >> 16) + ((ma * (ms & 64'hFFFF)) >> 16);
      neg = (pa < 0) != (score < 0);
      z = (neg ? -longint'(m) : longint'(m)) + longint'(pb);
      ez = 64'(z < 0 ? -z : z);
      q = exp_neg(ez);
      den = 64'd65536 + q;
      if (z >= 0) p = (q * 64'd65536 + den / 2) / den;
      else p = ((64'd1 << 32) + den / 2) / den;
      res.positive = score > 0;
      res.score = score[39:0];
      res.probability = p[16:0];
      return res;
    endfunction

    function void note_item(logic [1:0] fn, logic [5:0] vi, logic [6:0] ei,
                            logic [31:0] val, logic lst);
      case (fn)
        FUNC_VECTOR:  sv_mem[vi*FEAT_SLOTS+ei] = sat16(int'(val));
        FUNC_COEF:    coef_mem[vi] = val;
        FUNC_FEATURE: begin
          feat_mem[ei] = sat16(int'(val));
          if (lst) begin
            feat_len = ei + 1;
            pending.push_back(classify());
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result pos=%0b score=%h prob=%h", $time,
                 got.positive, got.score, got.probability);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.positive !== want.positive) begin
        $display("%0t: positive expected %0b actual %0b", $time, want.positive, got.positive);
        errors++;
      end
      if (got.score !== want.score) begin
        $display("%0t: score expected %h actual %h", $time, want.score, got.score);
        errors++;
      end
      if (got.probability !== want.probability) begin
        $display("%0t: probability expected %h actual %h", $time,
                 want.probability, got.probability);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           in_func_i = FUNC_VECTOR;
  logic [5:0]           in_vector_index_i = '0;
  logic [6:0]           in_element_index_i = '0;
  logic signed [31:0]   in_value_i = '0;
  logic                 in_last_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 out_positive_o;
  logic signed [39:0]   out_score_o;
  logic [16:0]          out_probability_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;

  svm_score_board sb = new();
  int  send_idle = 6;
  int  recv_stall = 54;
  int  sent = 0;
  logic holding = 1'b0;
  logic hold_go = 1'b0;
  logic feat_seen[FEAT_SLOTS];

  svm_kernel_classifier DUT (.*);

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk_i)
    out_ready_i <= !holding && ($urandom_range(99) >= recv_stall);

  // long receiver hold-off so the input side backs up
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    holding <= 1'b1;
    repeat (3000) @(posedge clk_i);
    holding <= 1'b0;
  end

  // result monitor
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({out_positive_o, out_score_o, out_probability_o});

  // run limit
  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send(logic [1:0] fn, logic [5:0] vi, logic [6:0] ei,
                      logic [31:0] val, logic lst);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_func_i <= fn;
    in_vector_index_i <= vi;
    in_element_index_i <= ei;
    in_value_i <= val;
    in_last_i <= lst;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(fn, vi, ei, val, lst);
    if (fn == FUNC_FEATURE) feat_seen[ei] = 1'b1;
    if (fn != 2'd3) sent++;
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= d;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, d);
  endtask

  // block is idle: all verdicts in and any load item drained
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_s32();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($urandom_range(0, 262143)) - 32'd131072;
    endcase
  endfunction

  function automatic logic [31:0] pick_element();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 65535)) - 32'd32768;
      default: return 32'($urandom_range(0, 4095)) - 32'd2048;
    endcase
  endfunction

  task automatic rand_cfg(logic [1:0] mode);
    logic [31:0] g;
    case ($urandom_range(5))
      0: g = 32'hFF_FFFF;
      1: g = 0;
      2: g = $urandom;
      default: g = $urandom_range(0, 8192);
    endcase
    write_cfg(REG_KERNEL_MODE, {30'd0, mode});
    write_cfg(REG_GAMMA, g);
    write_cfg(REG_COEF_ZERO, pick_s32());
    write_cfg(REG_POLY_DEGREE, $urandom_range(0, 15));
    write_cfg(REG_RHO, pick_s32());
    write_cfg(REG_PROB_A, ($urandom_range(3) == 0) ? pick_s32()
                          : 32'($urandom_range(0, 131072)) - 32'd65536);
    write_cfg(REG_PROB_B, pick_s32());
    if ($urandom_range(9) == 0 && mode != KERN_RBF) write_cfg(REG_VECTOR_COUNT, 64);
    else if ($urandom_range(19) == 0) write_cfg(REG_VECTOR_COUNT, 0);
    else write_cfg(REG_VECTOR_COUNT, $urandom_range(1, 8));
  endtask

  // one well-formed feature: elements 0..len-1, last on the final one
  task automatic feed_feature(int len);
    for (int i = 0; i < len; i++)
      send(FUNC_FEATURE, $urandom, i, pick_element(), i == len - 1);
  endtask

  task automatic random_burst(int count);
    int stop, r, pre;
    stop = sent + count;
    while (sent < stop) begin
      r = $urandom_range(99);
      if (r < 30)
        send(FUNC_VECTOR, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 7),
             ($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 15),
             pick_element(), $urandom);
      else if (r < 40)
        send(FUNC_COEF, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 7),
             $urandom, pick_s32(), $urandom);
      else if (r < 45)
        send(2'd3, $urandom, $urandom, $urandom, $urandom);
      else if (r < 55) begin
        // stray element, or a last on an already written prefix
        pre = 0;
        while (pre < FEAT_SLOTS && feat_seen[pre]) pre++;
        if (pre > 0 && $urandom_range(1) == 0)
          send(FUNC_FEATURE, $urandom, $urandom_range(0, pre - 1), pick_element(), 1'b1);
        else
          send(FUNC_FEATURE, $urandom, $urandom, pick_element(), 1'b0);
      end else
        feed_feature(($urandom_range(19) == 0) ? $urandom_range(13, 128)
                                              : $urandom_range(1, 12));
    end
  endtask

  task automatic random_phase();
    int stop;
    stop = sent + PHASE_ITEMS;
    while (sent < stop) begin
      wait_idle();
      rand_cfg($urandom_range(0, 3));
      random_burst(30);
    end
  endtask

  initial begin
    foreach (feat_seen[i]) feat_seen[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: no model, ignored items, load extremes
    send(FUNC_FEATURE, 0, 0, 32'h7FFF_FFFF, 1'b1);
    send(2'd3, 6'h3F, 7'h7F, 32'hFFFF_FFFF, 1'b1);
    send(FUNC_VECTOR, 0, 0, 32'h7FFF_FFFF, 1'b1);
    send(FUNC_VECTOR, 0, 1, 32'h8000_0000, 1'b0);
    send(FUNC_VECTOR, 6'h3F, 7'h7F, 32'hFFFF_FFFB, 1'b0);
    send(FUNC_VECTOR, 1, 2, 32'd2048, 1'b0);
    send(FUNC_COEF, 0, 0, 32'h7FFF_FFFF, 1'b1);
    send(FUNC_COEF, 6'h3F, 0, 32'h8000_0000, 1'b0);
    send(FUNC_COEF, 1, 0, 32'd65536, 1'b0);
    send(FUNC_FEATURE, 0, 1, 32'h8000_0000, 1'b0);
    send(FUNC_FEATURE, 0, 2, 32'd1234, 1'b1);

    // too many vectors, degree zero polynomial
    wait_idle();
    write_cfg(REG_UNUSED, 32'hFFFF_FFFF);
    write_cfg(REG_VECTOR_COUNT, 127);
    write_cfg(REG_KERNEL_MODE, {30'd0, KERN_POLY});
    write_cfg(REG_POLY_DEGREE, 0);
    send(FUNC_FEATURE, 0, 2, 32'd1000, 1'b1);
    wait_idle();
    write_cfg(REG_KERNEL_MODE, {30'd0, KERN_NONE});
    send(FUNC_FEATURE, 0, 0, 32'd4096, 1'b1);
    wait_idle();
    write_cfg(REG_KERNEL_MODE, {30'd0, KERN_LINEAR});
    write_cfg(REG_VECTOR_COUNT, 2);
    send(FUNC_FEATURE, 0, 2, 32'h7FFF_FFFF, 1'b1);
    wait_idle();
    write_cfg(REG_KERNEL_MODE, {30'd0, KERN_RBF});
    write_cfg(REG_GAMMA, 32'hFF_FFFF);
    send(FUNC_FEATURE, 0, 2, 32'h8000_0000, 1'b1);

    // all-maximum and all-minimum register sets
    wait_idle();
    write_cfg(REG_KERNEL_MODE, {30'd0, KERN_POLY});
    write_cfg(REG_COEF_ZERO, 32'h7FFF_FFFF);
    write_cfg(REG_POLY_DEGREE, 15);
    write_cfg(REG_RHO, 32'h7FFF_FFFF);
    write_cfg(REG_PROB_A, 32'h7FFF_FFFF);
    write_cfg(REG_PROB_B, 32'h7FFF_FFFF);
    send(FUNC_FEATURE, 0, 1, 32'd2048, 1'b1);
    wait_idle();
    write_cfg(REG_GAMMA, 0);
    write_cfg(REG_COEF_ZERO, 32'h8000_0000);
    write_cfg(REG_RHO, 32'h8000_0000);
    write_cfg(REG_PROB_A, 32'h8000_0000);
    write_cfg(REG_PROB_B, 32'h8000_0000);
    send(FUNC_FEATURE, 0, 2, 32'hFFFF_F800, 1'b1);

    // random phases with different idle patterns
    random_phase();
    send_idle = 54;
    recv_stall = 6;
    hold_go = 1'b1;
    random_phase();
    send_idle = 0;
    recv_stall = 0;
    random_phase();

    // full-size runs: all vectors, full feature length
    wait_idle();
    rand_cfg(KERN_RBF);
    write_cfg(REG_VECTOR_COUNT, 64);
    feed_feature(128);
    wait_idle();
    write_cfg(REG_KERNEL_MODE, {30'd0, KERN_LINEAR});
    send(FUNC_FEATURE, 0, 127, pick_element(), 1'b1);

    wait_idle();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
